/* src/aesbc_pkg.sv */
package aesbc_pkg;

    typedef logic [7:0]   byte_t;
    typedef logic [31:0]  word_t;
    typedef logic [127:0] block_t;
    typedef logic [5:0]   kidx_t;
    typedef logic [3:0]   round_t;

    typedef enum logic [2:0] {
        REG_KEY_SIZE = 3'd0,
        REG_KEY_W0   = 3'd1,
        REG_KEY_W1   = 3'd2,
        REG_KEY_W2   = 3'd3,
        REG_KEY_W3   = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_KEY_LOAD,
        ST_KEY_EXPAND,
        ST_IDLE,
        ST_ROUND,
        ST_DONE
    } state_t;

    // Control handed from the sequencer to the round cells
    typedef struct packed {
        logic   load;
        logic   step;
        logic   decrypt;
        logic   last;
    } cell_ctrl_t;

    localparam int unsigned KeyWords = 60;
    // Words per bank when the schedule is split by column
    localparam int unsigned KeySlots = KeyWords / 4;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,
        8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,
        8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,
        8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,
        8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,
        8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,
        8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,
        8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,
        8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,
        8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,
        8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
        8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,
        8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,
        8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,
        8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,
        8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,
        8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic byte_t xt(input byte_t b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic word_t sub_word(input word_t w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

/* src/aesbc_if.sv */
interface aesbc_in_if;
    logic   valid;
    logic   ready;
    logic   operation;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    modport source (output valid, operation, block_hi, block_lo, input ready);
    modport sink (input valid, operation, block_hi, block_lo, output ready);
endinterface

interface aesbc_out_if;
    logic   valid;
    logic   ready;
    logic [63:0] result_hi;
    logic [63:0] result_lo;
    modport source (output valid, result_hi, result_lo, input ready);
    modport sink (input valid, result_hi, result_lo, output ready);
endinterface

interface aesbc_cfg_if;
    logic   valid;
    logic   ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/aesbc_col_cell.sv */
// One column of the state: applies a round to its four bytes, taking the
// shifted-in bytes from its neighbors over the row wires.
module aesbc_col_cell (
    input  logic                 clk,
    input  aesbc_pkg::cell_ctrl_t ctrl,
    input  aesbc_pkg::word_t     load_col,
    input  aesbc_pkg::word_t     key_col,
    input  aesbc_pkg::word_t     shifted_col,
    output aesbc_pkg::word_t     col
);

    aesbc_pkg::word_t col_reg;
    aesbc_pkg::word_t col_next;
    aesbc_pkg::word_t subbed;
    aesbc_pkg::word_t keyed;
    aesbc_pkg::word_t mixed;

    // gmul by constants through xtime chains
    function automatic aesbc_pkg::word_t mix_fwd(input aesbc_pkg::word_t c);
        aesbc_pkg::byte_t a [4];
        aesbc_pkg::byte_t d [4];
        a[0] = c[31:24]; a[1] = c[23:16]; a[2] = c[15:8]; a[3] = c[7:0];
        for (int r = 0; r < 4; r++)
        begin
            d[r] = aesbc_pkg::xt(a[r]) ^ aesbc_pkg::xt(a[(r+1)%4]) ^ a[(r+1)%4]
                   ^ a[(r+2)%4] ^ a[(r+3)%4];
        end
        return {d[0], d[1], d[2], d[3]};
    endfunction

    function automatic aesbc_pkg::word_t mix_inv(input aesbc_pkg::word_t c);
        aesbc_pkg::byte_t a [4];
        aesbc_pkg::byte_t x2 [4];
        aesbc_pkg::byte_t x4 [4];
        aesbc_pkg::byte_t x8 [4];
        aesbc_pkg::byte_t m9 [4];
        aesbc_pkg::byte_t mb [4];
        aesbc_pkg::byte_t md [4];
        aesbc_pkg::byte_t me [4];
        aesbc_pkg::byte_t d [4];
        a[0] = c[31:24]; a[1] = c[23:16]; a[2] = c[15:8]; a[3] = c[7:0];
        for (int k = 0; k < 4; k++)
        begin
            x2[k] = aesbc_pkg::xt(a[k]);
            x4[k] = aesbc_pkg::xt(x2[k]);
            x8[k] = aesbc_pkg::xt(x4[k]);
            m9[k] = x8[k] ^ a[k];
            mb[k] = x8[k] ^ x2[k] ^ a[k];
            md[k] = x8[k] ^ x4[k] ^ a[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        for (int r = 0; r < 4; r++)
        begin
            d[r] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
        end
        return {d[0], d[1], d[2], d[3]};
    endfunction

    // Substitute the shifted bytes
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            subbed[31-8*r -: 8] = ctrl.decrypt ?
                aesbc_pkg::INV_SBOX[shifted_col[31-8*r -: 8]] :
                aesbc_pkg::SBOX[shifted_col[31-8*r -: 8]];
        end
    end

    // Encrypt: sub, shift, mix, key. Decrypt: shift, sub, key, inverse mix.
    always_comb
    begin
        keyed = ctrl.decrypt ? (subbed ^ key_col) : 32'h0;
        mixed = ctrl.decrypt ? mix_inv(keyed) : mix_fwd(subbed);
        if (ctrl.load)
            col_next = load_col ^ key_col;
        else if (!ctrl.step)
            col_next = col_reg;
        else if (ctrl.decrypt)
            col_next = ctrl.last ? keyed : mixed;
        else
            col_next = (ctrl.last ? subbed : mixed) ^ key_col;
    end

    // Hold or advance the column
    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
    end

    assign col = col_reg;

endmodule

/* src/aesbc_key_store.sv */
// Round key store: key words from the registers, then one expansion word per
// cycle; read by round, four words at a time, one from each column bank.
module aesbc_key_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        key_size,
    input  logic [255:0]      key_bits,
    input  logic              rd_en,
    input  aesbc_pkg::round_t rd_round,
    output logic [127:0]      rd_key,
    output logic              busy
);

    aesbc_pkg::word_t hist_reg [8];
    aesbc_pkg::word_t rd_word [4];
    logic [5:0]        idx_reg;
    logic [5:0]        idx_next;
    logic [2:0]        phase_reg;
    logic [2:0]        phase_next;
    logic [7:0]        rc_reg;
    logic [7:0]        rc_next;
    logic              run_reg;
    logic              run_next;
    logic              init_reg;
    logic [3:0]        nk;
    logic [5:0]        total;
    aesbc_pkg::word_t  t_rot;
    aesbc_pkg::word_t  t_word;
    aesbc_pkg::word_t  new_word;
    aesbc_pkg::word_t  prev;
    aesbc_pkg::word_t  far;

    always_comb
    begin
        case (key_size)
            2'd0:    begin nk = 4'd4; total = 6'd44; end
            2'd1:    begin nk = 4'd6; total = 6'd52; end
            default: begin nk = 4'd8; total = 6'd60; end
        endcase
    end

    // History of the last nk words; the oldest sits at nk-1
    always_comb
    begin
        prev  = hist_reg[0];
        far   = hist_reg[nk[2:0] - 3'd1];
        t_rot = aesbc_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rc_reg, 24'h0};
        if (idx_reg < {2'b00, nk})
            t_word = key_bits[255 - 32*idx_reg[2:0] -: 32];
        else if (phase_reg == 3'd0)
            t_word = t_rot;
        else if (nk == 4'd8 && phase_reg == 3'd4)
            t_word = far ^ aesbc_pkg::sub_word(prev);
        else
            t_word = far ^ prev;
        new_word = (idx_reg < {2'b00, nk} || phase_reg != 3'd0) ? t_word : (far ^ t_rot);
    end

    // Advance the expansion counters
    always_comb
    begin
        idx_next   = idx_reg;
        phase_next = phase_reg;
        rc_next    = rc_reg;
        run_next   = run_reg;
        if (start)
        begin
            idx_next   = 6'd0;
            phase_next = 3'd0;
            rc_next    = 8'h01;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            idx_next = idx_reg + 6'd1;
            if (idx_reg >= {2'b00, nk} && phase_reg == 3'd0)
                rc_next = aesbc_pkg::xt(rc_reg);
            phase_next = (phase_reg == nk[2:0] - 3'd1) ? 3'd0 : phase_reg + 3'd1;
            if (idx_reg == total - 6'd1)
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            phase_reg <= '0;
            rc_reg    <= 8'h01;
            run_reg   <= 1'b0;
            init_reg  <= 1'b1;
        end
        else
        begin
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            rc_reg    <= rc_next;
            run_reg   <= run_next;
            init_reg  <= 1'b0;
        end
    end

    // Shift the history
    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            hist_reg[0] <= new_word;
            for (int k = 1; k < 8; k++)
                hist_reg[k] <= hist_reg[k-1];
        end
    end

    // One bank per key column, indexed by round
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        aesbc_pkg::word_t mem [aesbc_pkg::KeySlots];

        // Write this bank's words of the expansion
        always_ff @(posedge clk)
        begin
            if (run_reg && idx_reg[1:0] == 2'(b))
                mem[idx_reg[5:2]] <= new_word;
        end

        // Registered read of this column of one round key
        always_ff @(posedge clk)
        begin
            if (rd_en)
                rd_word[b] <= mem[rd_round];
        end
    end

    assign rd_key = {rd_word[0], rd_word[1], rd_word[2], rd_word[3]};
    assign busy   = run_reg | init_reg;

endmodule

/* src/aes_block_cipher_unit.sv */
// Channel | Dir | Word
// in      | in  | operation, block_hi, block_lo
// out     | out | result_hi, result_lo
// cfg     | in  | index (0 key_size, 1..4 key words), data
//
// A result becomes valid after these steps: the first key read in the accept
// cycle, the initial key add, Nr rounds one a cycle through the four column
// cells, then the load of the output register. The next block is taken only
// once the unit is back to idle after that load. After reset and after each
// key write the expansion runs one word a cycle; blocks are held off after the
// write until the expansion is done. A result waits in the output register;
// the next block is taken once the result register is emptied or being
// emptied, and not while a write waits.
module aes_block_cipher_unit (
    input  logic            clk,
    input  logic            rst_n,
    aesbc_in_if.sink        in_ch,
    aesbc_out_if.source     out_ch,
    aesbc_cfg_if.sink       cfg
);

    aesbc_pkg::state_t  state_reg;
    aesbc_pkg::state_t  state_next;
    logic [1:0]         key_size_reg;
    logic [255:0]       key_reg;
    logic               op_reg;
    logic [127:0]       blk_reg;
    aesbc_pkg::round_t  rnd_reg;
    aesbc_pkg::round_t  rnd_next;
    logic [127:0]       res_reg;
    logic               res_valid_reg;
    logic               res_valid_next;
    aesbc_pkg::round_t  nr;
    logic               cfg_fire;
    logic               in_fire;
    logic               exp_start_reg;
    logic               ks_busy;
    logic               rd_en;
    aesbc_pkg::round_t  rd_round;
    logic [127:0]       rd_key;
    aesbc_pkg::cell_ctrl_t ctrl;
    aesbc_pkg::word_t   cols [4];
    aesbc_pkg::word_t   shifted [4];
    logic               first_reg;

    assign nr = (key_size_reg == 2'd0) ? 4'd10 : (key_size_reg == 2'd1) ? 4'd12 : 4'd14;
    assign cfg.ready = (state_reg == aesbc_pkg::ST_IDLE)
                       || (state_reg == aesbc_pkg::ST_KEY_EXPAND);
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign in_ch.ready = (state_reg == aesbc_pkg::ST_IDLE) && !exp_start_reg && !cfg.valid
                         && (!res_valid_reg || out_ch.ready);
    assign in_fire = in_ch.valid && in_ch.ready;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg  <= 2'd0;
            key_reg       <= '0;
            exp_start_reg <= 1'b1;
        end
        else
        begin
            exp_start_reg <= 1'b0;
            if (cfg_fire)
            begin
                case (aesbc_pkg::reg_idx_t'(cfg.index))
                    aesbc_pkg::REG_KEY_SIZE: key_size_reg <= cfg.data[1:0];
                    aesbc_pkg::REG_KEY_W0:   key_reg[255:192] <= cfg.data;
                    aesbc_pkg::REG_KEY_W1:   key_reg[191:128] <= cfg.data;
                    aesbc_pkg::REG_KEY_W2:   key_reg[127:64] <= cfg.data;
                    aesbc_pkg::REG_KEY_W3:   key_reg[63:0] <= cfg.data;
                    default: ;
                endcase
                if (cfg.index <= aesbc_pkg::REG_KEY_W3)
                    exp_start_reg <= 1'b1;
            end
        end
    end

    aesbc_key_store u_keys (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (exp_start_reg),
        .key_size (key_size_reg),
        .key_bits (key_reg),
        .rd_en    (rd_en),
        .rd_round (rd_round),
        .rd_key   (rd_key),
        .busy     (ks_busy)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aesbc_pkg::ST_KEY_LOAD:   state_next = aesbc_pkg::ST_KEY_EXPAND;
            aesbc_pkg::ST_KEY_EXPAND: if (!ks_busy && !exp_start_reg && !cfg_fire)
                                          state_next = aesbc_pkg::ST_IDLE;
            aesbc_pkg::ST_IDLE:       if (cfg_fire)
                                          state_next = aesbc_pkg::ST_KEY_EXPAND;
                                      else if (in_fire)
                                          state_next = aesbc_pkg::ST_ROUND;
            aesbc_pkg::ST_ROUND:      if (!first_reg && rnd_reg == nr)
                                          state_next = aesbc_pkg::ST_DONE;
            aesbc_pkg::ST_DONE:       state_next = aesbc_pkg::ST_IDLE;
            default:                  state_next = aesbc_pkg::ST_IDLE;
        endcase
    end

    // Outputs: key reads one round ahead, cell control, round count
    always_comb
    begin
        rd_en    = 1'b0;
        rd_round = rnd_reg;
        rnd_next = rnd_reg;
        ctrl     = '0;
        ctrl.decrypt = op_reg;
        case (state_reg)
            aesbc_pkg::ST_IDLE:
            begin
                rd_en    = in_fire;
                rd_round = in_ch.operation ? nr : 4'd0;
                rnd_next = 4'd1;
            end
            aesbc_pkg::ST_ROUND:
            begin
                ctrl.load  = first_reg;
                ctrl.step  = !first_reg;
                ctrl.last  = (rnd_reg == nr);
                if (!first_reg)
                    rnd_next = rnd_reg + 4'd1;
                rd_en      = (rnd_reg != nr);
                rd_round   = op_reg ? nr - rnd_next : rnd_next;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aesbc_pkg::ST_KEY_LOAD;
            rnd_reg   <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            first_reg <= in_fire;
        end
    end

    // Latch the block
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= in_ch.operation;
            blk_reg <= {in_ch.block_hi, in_ch.block_lo};
        end
    end

    // Row wires between cells: ShiftRows forward or inverse
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                shifted[c][31-8*r -: 8] = op_reg ?
                    cols[(c+4-r)%4][31-8*r -: 8] : cols[(c+r)%4][31-8*r -: 8];
            end
        end
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_cell
        aesbc_col_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .load_col    (blk_reg[127-32*c -: 32]),
            .key_col     (rd_key[127-32*c -: 32]),
            .shifted_col (shifted[c]),
            .col         (cols[c])
        );
    end

    // Output register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (out_ch.ready)
            res_valid_next = 1'b0;
        if (state_reg == aesbc_pkg::ST_DONE)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == aesbc_pkg::ST_DONE)
            res_reg <= {cols[0], cols[1], cols[2], cols[3]};
    end

    assign out_ch.valid     = res_valid_reg;
    assign out_ch.result_hi = res_reg[127:64];
    assign out_ch.result_lo = res_reg[63:0];

endmodule

/* src/aesbc_checker.sv */
module aesbc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic cfg_valid,
    input logic cfg_ready
);

    // A taken block shuts the input until its result is out
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken twice in a row");

    // No result rises on out_valid straight after a block is taken
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##1 !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("result too early");

    // Result held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");

    // A config write blocks the next input edge
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> !in_ready)
        else $error("input taken during key expansion");

endmodule

bind aes_block_cipher_unit aesbc_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);

/* tb/sv/aes_block_checker.sv */
module aes_block_checker
    import aesbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    aesbc_in_if.sink    in_mon,
    aesbc_out_if.sink   out_mon,
    aesbc_cfg_if.sink   cfg_mon,
    output int          fail_count,
    output int          pending_count,
    output int          block_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0]  key_len;
    logic [63:0] key_reg [4];
    word_t       sched_words [KeyWords];
    block_t      expected_blocks [$];

    function automatic byte_t sbox_fwd(input byte_t b);
        word_t w;
        w = sub_word({24'd0, b});
        return w[7:0];
    endfunction

    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        byte_t acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= a;
            a = xt(a);
        end
        return acc;
    endfunction

    function automatic int rounds_for_len();
        return (key_len == 2'd0) ? 10 : (key_len == 2'd1) ? 12 : 14;
    endfunction

    // Rebuild the whole key schedule from the registers
    function automatic void expand_schedule();
        int    nr;
        int    nk;
        byte_t rc;
        word_t t;
        nr = rounds_for_len();
        nk = nr - 6;
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            sched_words[i] = i[0] ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
        for (int i = nk; i < 4 * (nr + 1); i++)
        begin
            t = sched_words[i - 1];
            if (i % nk == 0)
            begin
                t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'd0};
                rc = xt(rc);
            end
            else if (nk > 6 && i % nk == 4)
                t = sub_word(t);
            sched_words[i] = sched_words[i - nk] ^ t;
        end
    endfunction

    function automatic void add_round_key(ref byte_t s [16], input int rnd);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                s[r + 4 * c] ^= sched_words[4 * rnd + c][31 - 8 * r -: 8];
    endfunction

    function automatic void shift_rows(ref byte_t s [16], input bit inverse);
        byte_t t [16];
        t = s;
        for (int r = 1; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (inverse)
                    s[r + 4 * ((c + r) % 4)] = t[r + 4 * c];
                else
                    s[r + 4 * c] = t[r + 4 * ((c + r) % 4)];
    endfunction

    function automatic void mix_columns(ref byte_t s [16], input bit inverse);
        byte_t m [4];
        byte_t col [4];
        byte_t v;
        if (inverse)
            m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
                col[k] = s[k + 4 * c];
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                    v ^= gf_mul(m[(k + 4 - r) % 4], col[k]);
                s[r + 4 * c] = v;
            end
        end
    endfunction

    function automatic void sub_bytes(ref byte_t s [16], input bit inverse);
        byte_t inv_tab [256];
        for (int i = 0; i < 256; i++)
            inv_tab[sbox_fwd(i[7:0])] = i[7:0];
        for (int i = 0; i < 16; i++)
            s[i] = inverse ? inv_tab[s[i]] : sbox_fwd(s[i]);
    endfunction

    function automatic block_t cipher_block(input bit decrypt, input block_t blk);
        byte_t  s [16];
        block_t res;
        int     nr;
        nr = rounds_for_len();
        for (int i = 0; i < 16; i++)
            s[i] = blk[127 - 8 * i -: 8];
        if (!decrypt)
        begin
            add_round_key(s, 0);
            for (int r = 1; r < nr; r++)
            begin
                sub_bytes(s, 1'b0);
                shift_rows(s, 1'b0);
                mix_columns(s, 1'b0);
                add_round_key(s, r);
            end
            sub_bytes(s, 1'b0);
            shift_rows(s, 1'b0);
            add_round_key(s, nr);
        end
        else
        begin
            add_round_key(s, nr);
            for (int r = nr - 1; r > 0; r--)
            begin
                shift_rows(s, 1'b1);
                sub_bytes(s, 1'b1);
                add_round_key(s, r);
                mix_columns(s, 1'b1);
            end
            shift_rows(s, 1'b1);
            sub_bytes(s, 1'b1);
            add_round_key(s, 0);
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = s[i];
        return res;
    endfunction

    assign pending_count = expected_blocks.size();

    // Track registers, predict on accepted blocks, compare on results
    always @(posedge clk or negedge rst_n)
    begin
        block_t got;
        block_t want;
        if (!rst_n)
        begin
            key_len = 2'd0;
            for (int i = 0; i < 4; i++)
                key_reg[i] = 64'd0;
            expand_schedule();
            expected_blocks.delete();
            fail_count <= 0;
            block_count <= 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                if (cfg_mon.index == REG_KEY_SIZE)
                    key_len = (cfg_mon.data[1:0] == 2'd3) ? 2'd2 : cfg_mon.data[1:0];
                else if (cfg_mon.index <= REG_KEY_W3)
                    key_reg[2'(cfg_mon.index - 3'd1)] = cfg_mon.data;
                expand_schedule();
            end
            if (in_mon.valid && in_mon.ready)
                expected_blocks.push_back(cipher_block(in_mon.operation,
                                                       {in_mon.block_hi, in_mon.block_lo}));
            if (out_mon.valid && out_mon.ready)
            begin
                got = {out_mon.result_hi, out_mon.result_lo};
                block_count <= block_count + 1;
                if (expected_blocks.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (got[127:64] !== want[127:64] || got[63:0] !== want[63:0])
                    begin
                        $display("%0t: result mismatch: expected %h_%h actual %h_%h",
                                 $time, want[127:64], want[63:0], got[127:64], got[63:0]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import aesbc_pkg::*;

    localparam int CycleLimit = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   block_count;
    int   cycle_count;
    int   enc_count;
    int   dec_count;
    int   stall_left;

    aesbc_in_if  in_ch ();
    aesbc_out_if out_ch ();
    aesbc_cfg_if cfg ();

    aes_block_cipher_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    aes_block_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (in_ch.sink),
        .out_mon       (out_ch.sink),
        .cfg_mon       (cfg.sink),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .block_count   (block_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("aes_block_cipher_unit test failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        else if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random receiver stall, a few long ones, with a calm stretch mid-run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (cycle_count > 3000 && cycle_count < 4000)
            out_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 49) == 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= $urandom_range(10, 40);
        end
        else
            out_ch.ready <= ($urandom_range(0, 9) < 6);
    end

    task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
        int g;
        g = gap_len();
        repeat (g) @(posedge clk);
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.block_hi <= hi;
        in_ch.block_lo <= lo;
        do
            @(posedge clk);
        while (!in_ch.ready);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        if (op)
            dec_count++;
        else
            enc_count++;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drain every pending result, then let the block settle
    task automatic drain();
        while (pending_count != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_key(input logic [1:0] ks, input logic [63:0] k0,
                           input logic [63:0] k1, input logic [63:0] k2,
                           input logic [63:0] k3);
        drain();
        write_reg(REG_KEY_SIZE, {62'd0, ks});
        write_reg(REG_KEY_W0, k0);
        write_reg(REG_KEY_W1, k1);
        write_reg(REG_KEY_W2, k2);
        write_reg(REG_KEY_W3, k3);
    endtask

    initial
    begin
        cycle_count = 0;
        enc_count = 0;
        dec_count = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = 1'b0;
        in_ch.block_hi = '0;
        in_ch.block_lo = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_KEY_SIZE;
        cfg.data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset key, extreme blocks, both directions
        send_block(1'b0, 64'd0, 64'd0);
        send_block(1'b1, 64'd0, 64'd0);
        send_block(1'b0, '1, '1);
        send_block(1'b1, '1, '1);
        // Standard vectors for each key length
        set_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'd0, 64'd0);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        set_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h1011121314151617, '1);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        set_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        // Key size three behaves as 256 bits; all-ones key
        set_key(2'd3, '1, '1, '1, '1);
        send_block(1'b0, 64'h8000000000000000, 64'd1);
        send_block(1'b1, 64'd1, 64'h8000000000000000);
        // Out-of-range register index is ignored
        drain();
        write_reg(reg_idx_t'(3'd7), 64'h0123456789abcdef);
        write_reg(reg_idx_t'(3'd5), '1);
        send_block(1'b0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);

        // Random phases with random keys
        for (int ph = 0; ph < 8; ph++)
        begin
            set_key(2'(ph % 4), rand64(), rand64(), rand64(), rand64());
            for (int n = 0; n < 50; n++)
            begin
                send_block(1'($urandom_range(0, 1)), rand64(), rand64());
                if (ph == 3 && n == 25)
                    drain();
            end
        end

        drain();
        $display("Covered %0d encrypt and %0d decrypt blocks, %0d results checked,",
                 enc_count, dec_count, block_count);
        $display("over all key lengths including size three and ignored registers.");
        if (fail_count == 0)
            $display("aes_block_cipher_unit test passed");
        else
            $display("aes_block_cipher_unit test failed");
        $finish;
    end
endmodule
